@@ src/jei_pkg.sv @@
// Package for the Josephus elimination index block.
// Holds widths, register indexes and the request/response types of the modulo unit.
// No dependencies; used by every module under src.
package jei_pkg;

  // Width of the configuration values and of the round number.
  localparam int VAL_W = 17;
  // Width of the modulo dividend: seat plus step can exceed 17 bits.
  localparam int DVD_W = VAL_W + 1;
  // Width of the seat reported on the result port.
  localparam int IDX_W = 16;
  // Width of the APB address: two registers at byte offsets 0 and 4.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam int MAX_PEOPLE_DEF = 65536;

  // Register indexes, taken from paddr[2].
  localparam logic REG_TOTAL_PEOPLE = 1'b0;
  localparam logic REG_STEP_COUNT   = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] remainder;
  } mod_rsp_t;

endpackage

@@ src/jei_mod_unit.sv @@
// Shared modulo unit: restoring remainder, one dividend bit per cycle.
// Depends on jei_pkg for widths and the request/response structs.
// A start loads the operands; done pulses once every dividend bit has been shifted in.
module jei_mod_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  jei_pkg::mod_req_t req,
  output jei_pkg::mod_rsp_t rsp
);

  localparam int CNT_W = $clog2(jei_pkg::DVD_W + 1);

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic [jei_pkg::VAL_W-1:0] rem_r, rem_nxt;
  logic [jei_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [jei_pkg::VAL_W-1:0] div_r, div_nxt;
  logic [jei_pkg::DVD_W-1:0] trial;
  logic [jei_pkg::DVD_W-1:0] div_ext;

  assign trial   = {rem_r, dvd_r[jei_pkg::DVD_W-1]};
  assign div_ext = {1'b0, div_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    if (req.start) begin
      cnt_nxt = CNT_W'(jei_pkg::DVD_W);
      rem_nxt = '0;
      dvd_nxt = req.dividend;
      div_nxt = req.divisor;
    end else if (cnt_r != '0) begin
      // The partial remainder stays below the divisor, so the subtraction fits.
      if (trial >= div_ext) begin
        rem_nxt = jei_pkg::VAL_W'(trial - div_ext);
      end else begin
        rem_nxt = trial[jei_pkg::VAL_W-1:0];
      end
      dvd_nxt  = {dvd_r[jei_pkg::DVD_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

@@ src/jei_seq.sv @@
// Sequencer that walks the Josephus recurrence one circle size at a time.
// Depends on jei_pkg and drives the shared jei_mod_unit for every step.
// Checks the round, seeds the seat, then issues one modulo per larger circle.
module jei_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [jei_pkg::VAL_W-1:0] round_in,
  input  logic [jei_pkg::VAL_W-1:0] people,
  input  logic [jei_pkg::VAL_W-1:0] step,
  output logic                      busy,
  output logic                      res_valid,
  output logic [jei_pkg::IDX_W-1:0] res_index,
  output logic                      res_bad
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  localparam int VW = jei_pkg::VAL_W;
  localparam int DW = jei_pkg::DVD_W;

  state_t                    state_r, state_nxt;
  logic [VW-1:0]             size_r, size_nxt;
  logic [VW-1:0]             people_r, people_nxt;
  logic [VW-1:0]             step_r, step_nxt;
  logic                      start_r, start_nxt;
  logic [DW-1:0]             dividend_r, dividend_nxt;
  logic [VW-1:0]             divisor_r, divisor_nxt;
  logic                      valid_r, valid_nxt;
  logic [jei_pkg::IDX_W-1:0] index_r, index_nxt;
  logic                      bad_r, bad_nxt;
  logic [VW-1:0]             first_size;
  jei_pkg::mod_req_t         mod_req;
  jei_pkg::mod_rsp_t         mod_rsp;

  // Circle size at the requested removal; valid only when the round is in range.
  assign first_size = people - round_in + VW'(1);

  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    people_nxt   = people_r;
    step_nxt     = step_r;
    start_nxt    = 1'b0;
    dividend_nxt = dividend_r;
    divisor_nxt  = divisor_r;
    valid_nxt    = 1'b0;
    index_nxt    = index_r;
    bad_nxt      = bad_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (round_in == '0 || round_in > people) begin
            valid_nxt = 1'b1;
            bad_nxt   = 1'b1;
            index_nxt = '0;
          end else begin
            size_nxt     = first_size;
            people_nxt   = people;
            step_nxt     = step;
            dividend_nxt = {1'b0, step} + {1'b0, first_size} - DW'(1);
            divisor_nxt  = first_size;
            start_nxt    = 1'b1;
            state_nxt    = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (mod_rsp.done) begin
          if (size_r == people_r) begin
            valid_nxt = 1'b1;
            bad_nxt   = 1'b0;
            index_nxt = mod_rsp.remainder[jei_pkg::IDX_W-1:0];
            state_nxt = ST_IDLE;
          end else begin
            size_nxt     = size_r + VW'(1);
            dividend_nxt = {1'b0, mod_rsp.remainder} + {1'b0, step_r};
            divisor_nxt  = size_r + VW'(1);
            start_nxt    = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    people_r   <= people_nxt;
    step_r     <= step_nxt;
    dividend_r <= dividend_nxt;
    divisor_r  <= divisor_nxt;
    index_r    <= index_nxt;
    bad_r      <= bad_nxt;
  end

  assign mod_req.start    = start_r;
  assign mod_req.dividend = dividend_r;
  assign mod_req.divisor  = divisor_r;

  jei_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign busy      = (state_r != ST_IDLE);
  assign res_valid = valid_r;
  assign res_index = index_r;
  assign res_bad   = bad_r;

  // A modulo is only launched for an item that is being worked on.
  a_start_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> state_r == ST_RUN)
    else $error("modulo launched outside of a run");

  // The circle never grows past the number of people.
  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> size_r <= people_r && size_r != '0)
    else $error("circle size out of range");

  // Every remainder from the shared unit is below its modulus.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && mod_rsp.done |-> mod_rsp.remainder < divisor_r)
    else $error("remainder not below modulus");

  // A rejected round reports seat zero.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && bad_r |-> index_r == '0)
    else $error("bad round with nonzero seat");

endmodule

@@ src/josephus_elimination_index.sv @@
// Top level of the Josephus elimination index block: APB registers and sequencer.
// Depends on jei_pkg, jei_seq and jei_mod_unit.
//
// Channel      Ports                                         Direction
// input        start, busy, in_elimination_round             in (busy out)
// result       out_valid, out_eliminated_index, out_bad_round out
// config       psel, penable, pwrite, paddr, pwdata, prdata  in/out (pready out)
//
// A round that is 0 or above the circle size answers in the cycle after start with out_bad_round set.
// A valid round n takes n modulo steps, one per circle size from N - n + 1 up to N,
// each run on the shared one-bit-per-cycle modulo unit.
// busy is high while an item is at work; start is ignored then.
// Reset (rst_n low, synchronous) sets both registers to 1 and drops any item in flight.
// Each result stands on the out_ ports for one cycle; the receiver cannot stall it.
module josephus_elimination_index #(
  parameter int MAX_PEOPLE = jei_pkg::MAX_PEOPLE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [jei_pkg::VAL_W-1:0]  in_elimination_round,
  output logic                       out_valid,
  output logic [jei_pkg::IDX_W-1:0]  out_eliminated_index,
  output logic                       out_bad_round,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [jei_pkg::ADDR_W-1:0] paddr,
  input  logic [jei_pkg::DATA_W-1:0] pwdata,
  output logic [jei_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int VW = jei_pkg::VAL_W;

  logic [VW-1:0] total_people_r, total_people_nxt;
  logic [VW-1:0] step_count_r, step_count_nxt;
  logic          wr_transfer;
  logic [VW-1:0] people_eff;

  assign pready      = 1'b1;
  assign wr_transfer = psel && penable && pwrite && pready;

  always_comb begin
    total_people_nxt = total_people_r;
    step_count_nxt   = step_count_r;
    if (wr_transfer) begin
      case (paddr[2])
        jei_pkg::REG_TOTAL_PEOPLE: total_people_nxt = pwdata[VW-1:0];
        jei_pkg::REG_STEP_COUNT:   step_count_nxt   = pwdata[VW-1:0];
        default: begin
          total_people_nxt = total_people_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_people_r <= VW'(1);
      step_count_r   <= VW'(1);
    end else begin
      total_people_r <= total_people_nxt;
      step_count_r   <= step_count_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      jei_pkg::REG_TOTAL_PEOPLE: prdata = {{(jei_pkg::DATA_W-VW){1'b0}}, total_people_r};
      jei_pkg::REG_STEP_COUNT:   prdata = {{(jei_pkg::DATA_W-VW){1'b0}}, step_count_r};
      default:                   prdata = '0;
    endcase
  end

  // The circle is capped at MAX_PEOPLE; above the register range the cap never applies.
  assign people_eff = (32'(total_people_r) > 32'(MAX_PEOPLE)) ? VW'(MAX_PEOPLE)
                                                              : total_people_r;

  jei_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .round_in  (in_elimination_round),
    .people    (people_eff),
    .step      (step_count_r),
    .busy      (busy),
    .res_valid (out_valid),
    .res_index (out_eliminated_index),
    .res_bad   (out_bad_round)
  );

endmodule
